### rtl/battery_percent_gauge_unit_assert.svh
// assertion macros for the battery percent gauge
`ifndef BATTERY_PERCENT_GAUGE_UNIT_ASSERT_SVH
`define BATTERY_PERCENT_GAUGE_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BPG_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define BPG_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
		else $error(msg);

`endif

### rtl/bpg_pkg.sv
// types and constants shared by the battery percent gauge
package bpg_pkg;

	localparam int unsigned RAW_W   = 10;
	localparam int unsigned MV_W    = 13;
	localparam int unsigned PCT_W   = 8;
	localparam int unsigned CPCT_W  = 7;
	localparam int unsigned POINTS  = 6;
	localparam int unsigned QUO_W   = 5;
	localparam int unsigned DEN_W   = 8;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_POWER_PIN_WIRED   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ADC_FULL_SCALE_MV = 2'd1;

	localparam logic [MV_W-1:0] RESET_FULL_SCALE_MV = 13'd4800;

	localparam logic [PCT_W-1:0] PCT_UNKNOWN = 8'd255;
	localparam logic [PCT_W-1:0] PCT_FULL    = 8'd100;
	localparam logic [PCT_W-1:0] PCT_CHARGE_CAP = 8'd99;

	typedef logic [MV_W-1:0]   mv_t;
	typedef logic [CPCT_W-1:0] cpct_t;

	localparam mv_t CURVE_MV [POINTS] = '{
		13'd3500, 13'd3616, 13'd3723, 13'd3776, 13'd3979, 13'd4180
	};
	localparam cpct_t CURVE_PCT [POINTS] = '{
		7'd0, 7'd3, 7'd22, 7'd48, 7'd79, 7'd100
	};

	typedef struct packed {
		logic [RAW_W-1:0] adc_raw;
		logic             adc_valid;
		logic             charging;
		logic             ext_power;
	} gauge_in_t;

	typedef struct packed {
		logic [PCT_W-1:0] percent;
		logic             percent_known;
		logic             full_flag;
		logic [MV_W-1:0]  battery_mv;
	} gauge_out_t;

endpackage

### rtl/battery_percent_gauge_unit.sv
// battery percent gauge: serial scaling, curve lookup and display hysteresis
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------------
//   input    | in_valid / in_ready    | in_data  (bpg_pkg::gauge_in_t)
//   output   | out_valid / out_ready  | out_data (bpg_pkg::gauge_out_t)
//   config   | cfg_we                 | cfg_index, cfg_wdata
//
// each item goes through these steps after acceptance: load, the bit-serial
// shift-add multiplier (one converter bit per cycle), segment select, the
// restoring divider (one quotient bit per cycle), finish.
// the result sits in an output register; a new item is taken while it waits,
// and the finish step stalls only if the previous result is still not taken.
// arst_n resets control state, the config registers and the gauge state.
module battery_percent_gauge_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  bpg_pkg::gauge_in_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output bpg_pkg::gauge_out_t                 out_data,
	input  logic                                cfg_we,
	input  logic [bpg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bpg_pkg::MV_W-1:0]            cfg_wdata
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_SEG  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	localparam int unsigned PROD_W = bpg_pkg::RAW_W + bpg_pkg::MV_W;
	localparam int unsigned NUM_W  = bpg_pkg::DEN_W + bpg_pkg::QUO_W;

	logic [2:0]                   state_q;
	logic [3:0]                   cnt_q;
	bpg_pkg::gauge_in_t           in_q;
	logic [bpg_pkg::RAW_W-1:0]    raw_q;
	logic [PROD_W-1:0]            acc_q;
	logic [bpg_pkg::DEN_W-1:0]    rem_q;
	logic [bpg_pkg::DEN_W-1:0]    den_q;
	logic [bpg_pkg::QUO_W-1:0]    num_lo_q;
	logic [bpg_pkg::QUO_W-1:0]    quo_q;
	bpg_pkg::cpct_t               base_q;

	logic                         cfg_wired_q;
	logic [bpg_pkg::MV_W-1:0]     cfg_scale_q;

	logic [bpg_pkg::PCT_W-1:0]    shown_q;
	logic                         have_q;
	logic                         full_q;

	bpg_pkg::gauge_out_t          out_q;
	logic                         out_valid_q;

	// multiplier step
	logic [bpg_pkg::MV_W:0]       mul_sum;
	// segment select
	bpg_pkg::mv_t                 mv;
	bpg_pkg::mv_t                 seg_diff;
	logic [bpg_pkg::DEN_W-1:0]    seg_den;
	logic [bpg_pkg::QUO_W-1:0]    seg_dp;
	bpg_pkg::cpct_t               seg_base;
	logic [NUM_W-1:0]             seg_num;
	// divider step
	logic [bpg_pkg::DEN_W:0]      div_trial;
	logic                         div_ge;
	// finish
	logic                         pwr;
	logic                         full_nx;
	bpg_pkg::cpct_t               pct_curve;
	logic [bpg_pkg::PCT_W-1:0]    pct_lim;
	logic [bpg_pkg::PCT_W-1:0]    pct_nx;
	logic                         fin_fire;
	bpg_pkg::gauge_out_t          res;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign fin_fire  = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	assign mul_sum = {1'b0, acc_q[PROD_W-1:bpg_pkg::RAW_W]}
		+ (raw_q[0] ? {1'b0, cfg_scale_q} : '0);
	assign mv = acc_q[PROD_W-1:bpg_pkg::RAW_W];

	always_comb begin
		seg_diff = '0;
		seg_den  = 8'd1;
		seg_dp   = '0;
		seg_base = bpg_pkg::CURVE_PCT[0];
		if (mv >= bpg_pkg::CURVE_MV[bpg_pkg::POINTS-1]) begin
			seg_base = bpg_pkg::CURVE_PCT[bpg_pkg::POINTS-1];
		end else if (mv > bpg_pkg::CURVE_MV[0]) begin
			// first segment whose upper point is not below the voltage
			for (int i = bpg_pkg::POINTS - 2; i >= 0; i--) begin
				if (mv <= bpg_pkg::CURVE_MV[i+1]) begin
					seg_diff = mv - bpg_pkg::CURVE_MV[i];
					seg_den  = bpg_pkg::DEN_W'(bpg_pkg::CURVE_MV[i+1] - bpg_pkg::CURVE_MV[i]);
					seg_dp   = bpg_pkg::QUO_W'(bpg_pkg::CURVE_PCT[i+1] - bpg_pkg::CURVE_PCT[i]);
					seg_base = bpg_pkg::CURVE_PCT[i];
				end
			end
		end
		seg_num = NUM_W'(seg_diff[bpg_pkg::DEN_W-1:0] * seg_dp);
	end

	assign div_trial = {rem_q, num_lo_q[bpg_pkg::QUO_W-1]};
	assign div_ge    = (div_trial >= {1'b0, den_q});

	always_comb begin
		pwr = cfg_wired_q ? in_q.ext_power : in_q.charging;
		full_nx = full_q;
		if (pwr && !in_q.charging) begin
			full_nx = 1'b1;
		end else if (!pwr) begin
			full_nx = 1'b0;
		end
		pct_curve = base_q + bpg_pkg::CPCT_W'(quo_q);
		pct_lim   = {1'b0, pct_curve};
		if (full_nx) begin
			pct_lim = bpg_pkg::PCT_FULL;
		end else if (in_q.charging && pct_lim > bpg_pkg::PCT_CHARGE_CAP) begin
			pct_lim = bpg_pkg::PCT_CHARGE_CAP;
		end
		pct_nx = pct_lim;
		// display only moves up on power and down without it
		if (have_q && shown_q <= bpg_pkg::PCT_FULL) begin
			if (pwr) begin
				if (pct_lim < shown_q) begin
					pct_nx = shown_q;
				end
			end else begin
				if (pct_lim > shown_q) begin
					pct_nx = shown_q;
				end
			end
		end
		if (in_q.adc_valid) begin
			res.percent       = pct_nx;
			res.percent_known = 1'b1;
			res.full_flag     = full_nx;
			res.battery_mv    = mv;
		end else begin
			res.percent       = bpg_pkg::PCT_UNKNOWN;
			res.percent_known = 1'b0;
			res.full_flag     = full_q;
			res.battery_mv    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_wired_q <= 1'b1;
			cfg_scale_q <= bpg_pkg::RESET_FULL_SCALE_MV;
		end else if (cfg_we) begin
			case (cfg_index)
				bpg_pkg::REG_POWER_PIN_WIRED:   cfg_wired_q <= cfg_wdata[0];
				bpg_pkg::REG_ADC_FULL_SCALE_MV: cfg_scale_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			shown_q     <= bpg_pkg::PCT_UNKNOWN;
			have_q      <= 1'b0;
			full_q      <= 1'b0;
		end else begin
			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_MUL;
						cnt_q   <= '0;
					end
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(bpg_pkg::RAW_W - 1)) begin
						state_q <= ST_SEG;
					end
				end
				ST_SEG: begin
					state_q <= ST_DIV;
					cnt_q   <= '0;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(bpg_pkg::QUO_W - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_fire) begin
						state_q <= ST_IDLE;
						if (in_q.adc_valid) begin
							shown_q <= pct_nx;
							have_q  <= 1'b1;
							full_q  <= full_nx;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					in_q  <= in_data;
					raw_q <= in_data.adc_raw;
					acc_q <= '0;
				end
			end
			ST_MUL: begin
				acc_q <= {mul_sum, acc_q[bpg_pkg::RAW_W-1:1]};
				raw_q <= raw_q >> 1;
			end
			ST_SEG: begin
				rem_q    <= seg_num[NUM_W-1:bpg_pkg::QUO_W];
				num_lo_q <= seg_num[bpg_pkg::QUO_W-1:0];
				den_q    <= seg_den;
				base_q   <= seg_base;
				quo_q    <= '0;
			end
			ST_DIV: begin
				rem_q    <= div_ge ? bpg_pkg::DEN_W'(div_trial - {1'b0, den_q})
					: div_trial[bpg_pkg::DEN_W-1:0];
				num_lo_q <= num_lo_q << 1;
				quo_q    <= {quo_q[bpg_pkg::QUO_W-2:0], div_ge};
			end
			ST_FIN: begin
				if (fin_fire) begin
					out_q <= res;
				end
			end
			default: ;
		endcase
	end

`include "battery_percent_gauge_unit_assert.svh"

	`BPG_ASSERT_NOW(a_known_in_range, clk, arst_n,
		out_valid && out_data.percent_known, out_data.percent <= bpg_pkg::PCT_FULL,
		"known percent above 100")
	`BPG_ASSERT_NOW(a_unknown_result, clk, arst_n,
		out_valid && !out_data.percent_known,
		out_data.percent == bpg_pkg::PCT_UNKNOWN && out_data.battery_mv == '0,
		"unknown item with percent or voltage set")
	`BPG_ASSERT_NOW(a_div_rem_bound, clk, arst_n,
		state_q == ST_DIV, rem_q < den_q, "divider remainder not below divisor")
	`BPG_ASSERT_NEXT(a_accept_starts, clk, arst_n,
		in_valid && in_ready, state_q == ST_MUL && !in_ready,
		"accepted item did not start the multiplier")

endmodule

### tb/tb_battery_percent_gauge_unit.sv
// testbench for the battery percent gauge: reading predictor, drivers and phase sequence
`timescale 1ns / 100ps

module tb_battery_percent_gauge_unit;

	localparam logic [bpg_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [bpg_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
	localparam int SETTLE_CYCLES   = 24;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int MAX_REPORTS     = 10;

	class gauge_scoreboard;
		bit                        pin_wired;
		logic [bpg_pkg::MV_W-1:0]  full_scale;
		logic [bpg_pkg::PCT_W-1:0] shown;
		bit                        shown_valid;
		bit                        full_latched;
		bpg_pkg::gauge_out_t       expected_readings[$];
		int                        mismatches;
		int                        readings_checked;
		int                        samples_noted;
		int                        n_invalid;
		int                        n_full;
		int                        n_capped;
		int                        n_held;

		function new();
			pin_wired = 1'b1;
			full_scale = bpg_pkg::RESET_FULL_SCALE_MV;
			shown = bpg_pkg::PCT_UNKNOWN;
			shown_valid = 1'b0;
			full_latched = 1'b0;
		endfunction

		function void write_reg(logic [bpg_pkg::CFG_IDX_W-1:0] idx,
				logic [bpg_pkg::MV_W-1:0] val);
			if (idx == bpg_pkg::REG_POWER_PIN_WIRED)
				pin_wired = val[0];
			else if (idx == bpg_pkg::REG_ADC_FULL_SCALE_MV)
				full_scale = val;
		endfunction

		function int pending();
			return expected_readings.size();
		endfunction

		// piecewise-linear voltage to percent, floor division, clamped at both ends
		function int unsigned curve_percent(int unsigned mv);
			int unsigned lo_mv, hi_mv, lo_pct, hi_pct;
			if (mv <= 32'(bpg_pkg::CURVE_MV[0]))
				return 32'(bpg_pkg::CURVE_PCT[0]);
			if (mv >= 32'(bpg_pkg::CURVE_MV[bpg_pkg::POINTS-1]))
				return 32'(bpg_pkg::CURVE_PCT[bpg_pkg::POINTS-1]);
			for (int k = 1; k < bpg_pkg::POINTS; k++) begin
				lo_mv = 32'(bpg_pkg::CURVE_MV[k-1]);
				hi_mv = 32'(bpg_pkg::CURVE_MV[k]);
				lo_pct = 32'(bpg_pkg::CURVE_PCT[k-1]);
				hi_pct = 32'(bpg_pkg::CURVE_PCT[k]);
				if (mv <= hi_mv)
					return lo_pct + ((mv - lo_mv) * (hi_pct - lo_pct)) / (hi_mv - lo_mv);
			end
			return 32'(bpg_pkg::CURVE_PCT[bpg_pkg::POINTS-1]);
		endfunction

		function void note_sample(bpg_pkg::gauge_in_t s);
			bpg_pkg::gauge_out_t r;
			logic [22:0]  product;
			int unsigned  mv;
			int unsigned  pct;
			int unsigned  raw_pct;
			bit           pwr;
			samples_noted++;
			if (!s.adc_valid) begin
				r.percent = bpg_pkg::PCT_UNKNOWN;
				r.percent_known = 1'b0;
				r.full_flag = full_latched;
				r.battery_mv = '0;
				n_invalid++;
			end else begin
				product = 23'(s.adc_raw) * 23'(full_scale);
				mv = 32'(product >> 10);
				pct = curve_percent(mv);
				pwr = pin_wired ? s.ext_power : s.charging;
				if (pwr && !s.charging)
					full_latched = 1'b1;
				else if (!pwr)
					full_latched = 1'b0;
				if (full_latched) begin
					pct = 32'(bpg_pkg::PCT_FULL);
					n_full++;
				end else if (s.charging && pct > 32'(bpg_pkg::PCT_CHARGE_CAP)) begin
					pct = 32'(bpg_pkg::PCT_CHARGE_CAP);
					n_capped++;
				end
				// display only rises on power and only falls without it
				raw_pct = pct;
				if (shown_valid && shown <= bpg_pkg::PCT_FULL) begin
					if (pwr && pct < 32'(shown))
						pct = 32'(shown);
					else if (!pwr && pct > 32'(shown))
						pct = 32'(shown);
				end
				if (pct != raw_pct)
					n_held++;
				shown = pct[bpg_pkg::PCT_W-1:0];
				shown_valid = 1'b1;
				r.percent = shown;
				r.percent_known = 1'b1;
				r.full_flag = full_latched;
				r.battery_mv = mv[bpg_pkg::MV_W-1:0];
			end
			expected_readings.push_back(r);
		endfunction

		function void check_reading(bpg_pkg::gauge_out_t got);
			bpg_pkg::gauge_out_t want;
			if (expected_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected reading: pct=%0d known=%0d full=%0d mv=%0d",
						got.percent, got.percent_known, got.full_flag, got.battery_mv);
				return;
			end
			want = expected_readings.pop_front();
			readings_checked++;
			if (got.percent !== want.percent || got.percent_known !== want.percent_known ||
					got.full_flag !== want.full_flag || got.battery_mv !== want.battery_mv) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("reading %0d mismatch: exp pct=%0d known=%0d full=%0d mv=%0d",
						readings_checked, want.percent, want.percent_known, want.full_flag,
						want.battery_mv);
					$display("    got pct=%0d known=%0d full=%0d mv=%0d",
						got.percent, got.percent_known, got.full_flag, got.battery_mv);
				end
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	bpg_pkg::gauge_in_t            in_data = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	bpg_pkg::gauge_out_t           out_data;
	logic                          cfg_we = 1'b0;
	logic [bpg_pkg::CFG_IDX_W-1:0] cfg_index = bpg_pkg::REG_POWER_PIN_WIRED;
	logic [bpg_pkg::MV_W-1:0]      cfg_wdata = '0;

	gauge_scoreboard sb;
	int  idle_pct = 0;
	int  stall_pct = 0;
	bit  hold_req = 1'b0;
	bit  plugged_in = 1'b0;
	bit  charge_on = 1'b0;
	int  quiet_cycles = 0;
	int  settings_used = 1;

	battery_percent_gauge_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// both channels are sampled at the edge, before any update of that step
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_reading(out_data);
			if (in_valid && in_ready)
				sb.note_sample(in_data);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", quiet_cycles);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// receiver: random stalls, or one long hold-off when asked
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	function automatic bpg_pkg::gauge_in_t sample(int raw, bit valid, bit chg, bit pwr);
		bpg_pkg::gauge_in_t s;
		s.adc_raw = raw[bpg_pkg::RAW_W-1:0];
		s.adc_valid = valid;
		s.charging = chg;
		s.ext_power = pwr;
		return s;
	endfunction

	// mostly plug/charge sequences with voltages near the curve, some pure noise
	function automatic bpg_pkg::gauge_in_t random_sample();
		bpg_pkg::gauge_in_t s;
		int unsigned lo, hi;
		if ($urandom_range(99) < 10) begin
			s.adc_raw = bpg_pkg::RAW_W'($urandom_range(1023));
			s.adc_valid = 1'($urandom_range(1));
			s.charging = 1'($urandom_range(1));
			s.ext_power = 1'($urandom_range(1));
			return s;
		end
		if ($urandom_range(99) < 12)
			plugged_in = !plugged_in;
		if (plugged_in) begin
			if ($urandom_range(99) < 20)
				charge_on = !charge_on;
		end else begin
			charge_on = ($urandom_range(99) < 8);
		end
		s.ext_power = plugged_in;
		s.charging = charge_on;
		s.adc_valid = ($urandom_range(99) >= 6);
		if (sb.full_scale >= 3500 && $urandom_range(99) < 75) begin
			lo = (3400 * 1024) / 32'(sb.full_scale);
			hi = (4300 * 1024) / 32'(sb.full_scale);
			if (hi > 1023)
				hi = 1023;
			s.adc_raw = bpg_pkg::RAW_W'($urandom_range(hi, lo));
		end else begin
			s.adc_raw = bpg_pkg::RAW_W'($urandom_range(1023));
		end
		return s;
	endfunction

	// leaves valid high on return so that a following item can go back to back
	task automatic send_item(bpg_pkg::gauge_in_t d);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= d;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [bpg_pkg::CFG_IDX_W-1:0] idx,
			logic [bpg_pkg::MV_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic reconfigure(bit pin, logic [bpg_pkg::MV_W-1:0] scale);
		drain();
		write_reg(REG_SPARE_2, bpg_pkg::MV_W'($urandom_range(8191)));
		write_reg(bpg_pkg::REG_POWER_PIN_WIRED, {12'($urandom_range(4095)), pin});
		write_reg(bpg_pkg::REG_ADC_FULL_SCALE_MV, scale);
		write_reg(REG_SPARE_3, bpg_pkg::MV_W'($urandom_range(8191)));
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic run_phase(int n, int gap_pct, int ready_pct, bit pin,
			logic [bpg_pkg::MV_W-1:0] scale, bit with_hold, bit with_pause);
		reconfigure(pin, scale);
		idle_pct = gap_pct;
		stall_pct = ready_pct;
		for (int k = 0; k < n; k++) begin
			if (with_hold && k == 20)
				hold_req = 1'b1;
			if (with_pause && k == n / 2)
				drain();
			send_item(random_sample());
		end
	endtask

	initial begin
		int leftover;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		drain();

		// reset settings: first sample, full latch, charge cap, hysteresis both ways
		send_item(sample(1023, 1'b0, 1'b1, 1'b1));
		send_item(sample(0, 1'b1, 1'b0, 1'b0));
		send_item(sample(1023, 1'b1, 1'b1, 1'b1));
		send_item(sample(1023, 1'b1, 1'b0, 1'b1));
		send_item(sample(0, 1'b0, 1'b0, 1'b0));
		send_item(sample(800, 1'b1, 1'b0, 1'b0));
		send_item(sample(1023, 1'b1, 1'b0, 1'b0));
		send_item(sample(0, 1'b1, 1'b1, 1'b1));
		send_item(sample(850, 1'b1, 1'b1, 1'b1));
		send_item(sample(770, 1'b1, 1'b0, 1'b0));
		send_item(sample(747, 1'b1, 1'b0, 1'b0));

		// no power pin: charging stands in; scale 4096 puts counts on curve points
		reconfigure(1'b0, 13'd4096);
		send_item(sample(875, 1'b1, 1'b0, 1'b1));
		send_item(sample(904, 1'b1, 1'b1, 1'b0));
		send_item(sample(944, 1'b1, 1'b1, 1'b0));
		send_item(sample(1023, 1'b1, 1'b1, 1'b1));
		send_item(sample(1023, 1'b1, 1'b0, 1'b1));
		send_item(sample(0, 1'b0, 1'b0, 1'b1));
		send_item(sample(512, 1'b1, 1'b0, 1'b0));

		run_phase(110, 0, 0, 1'b1, bpg_pkg::RESET_FULL_SCALE_MV, 1'b1, 1'b0);
		run_phase(110, 69, 0, 1'b0, 13'd8191, 1'b0, 1'b0);
		run_phase(110, 0, 69, 1'b1, 13'd0, 1'b0, 1'b0);
		run_phase(110, 24, 24, 1'b1, bpg_pkg::MV_W'($urandom_range(8191, 3500)),
			1'b0, 1'b1);
		run_phase(110, 0, 0, 1'b0, bpg_pkg::RESET_FULL_SCALE_MV, 1'b0, 1'b0);
		drain();

		leftover = sb.pending();
		if (leftover != 0)
			$display("%0d expected readings never arrived", leftover);
		$display("ran %0d samples (%0d invalid), %0d register settings, %0d readings checked",
			sb.samples_noted, sb.n_invalid, settings_used, sb.readings_checked);
		$display("full latch forced %0d, charge cap hit %0d, hysteresis held %0d",
			sb.n_full, sb.n_capped, sb.n_held);
		if (sb.mismatches == 0 && leftover == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/bpg_pkg.sv
rtl/battery_percent_gauge_unit.sv
tb/tb_battery_percent_gauge_unit.sv
